### src/srfc_pkg.sv
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types, constants and the CRC-16 byte update for the reply frame
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package srfc_pkg;

	localparam int IDX_W     = 5;
	localparam int FRAME_LEN = 19;

	localparam logic [IDX_W-1:0] IDX_FIRST   = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_SYNC2   = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_ADDR    = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_CMD     = IDX_W'(5);
	localparam logic [IDX_W-1:0] IDX_X_LO    = IDX_W'(9);
	localparam logic [IDX_W-1:0] IDX_X_HI    = IDX_W'(12);
	localparam logic [IDX_W-1:0] IDX_Y_LO    = IDX_W'(13);
	localparam logic [IDX_W-1:0] IDX_Y_HI    = IDX_W'(16);
	localparam logic [IDX_W-1:0] IDX_CRC_HI  = IDX_W'(17);
	localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(FRAME_LEN - 1);

	localparam logic [7:0]  SYNC_BYTE = 8'hA5;
	localparam logic [7:0]  CMD_BYTE  = 8'h01;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// register indexes on the config port
	localparam logic REG_EXP_ADDR = 1'b0;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SHORT  = 2'd1,
		ST_HEADER = 2'd2,
		ST_CRC    = 2'd3
	} status_t;

	// one live frame byte, tagged by the front end
	typedef struct packed {
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
		logic             short_end;
	} entry_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
	                                           input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### src/srfc_front.sv
// ----------------------------------------------------------------------------
// srfc_front
// Accepts input beats, tracks the byte position and drops bytes that follow
// a finished frame. Live bytes go to the queue tagged with their index.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            rx_byte,
	input  wire logic                  first_of_frame,
	input  wire logic                  last_of_frame,
	input  wire logic                  q_full,
	output logic                       q_push,
	output srfc_pkg::entry_t           q_entry
);

	logic [srfc_pkg::IDX_W-1:0] idx_q;
	logic                       done_q;
	logic [srfc_pkg::IDX_W-1:0] cur_idx;
	logic                       live;
	logic                       acc;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign cur_idx  = first_of_frame ? srfc_pkg::IDX_FIRST : idx_q;
	assign live     = first_of_frame || !done_q;
	assign q_push   = acc && live;

	always_comb begin
		q_entry.data      = rx_byte;
		q_entry.idx       = cur_idx;
		q_entry.short_end = last_of_frame && (cur_idx != srfc_pkg::IDX_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= srfc_pkg::IDX_FIRST;
			done_q <= 1'b0;
		end else if (acc && live) begin
			done_q <= (cur_idx == srfc_pkg::IDX_LAST) || last_of_frame;
			if (cur_idx != srfc_pkg::IDX_LAST) begin
				idx_q <= cur_idx + srfc_pkg::IDX_W'(1);
			end else begin
				idx_q <= cur_idx;
			end
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= srfc_pkg::IDX_LAST)
		else $error("byte index ran past the frame length");

	a_drop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && done_q && !first_of_frame) |-> !q_push)
		else $error("byte after a finished frame reached the queue");

endmodule

`default_nettype wire

### src/srfc_queue.sv
// ----------------------------------------------------------------------------
// srfc_queue
// Two-entry queue between the front end and the checker back end.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire srfc_pkg::entry_t  push_entry,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output srfc_pkg::entry_t       head
);

	srfc_pkg::entry_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full queue");

endmodule

`default_nettype wire

### src/srfc_back.sv
// ----------------------------------------------------------------------------
// srfc_back
// Runs the CRC, header checks and value capture on queued bytes and holds
// the per-frame result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        exp_addr,
	input  wire logic              head_valid,
	input  wire srfc_pkg::entry_t  head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [31:0]            x_bits,
	output logic [31:0]            y_bits
);

	logic [15:0] crc_q;
	logic        hdr_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [7:0]  crc_hi_q;

	logic              out_valid_q;
	srfc_pkg::status_t status_q;
	logic [31:0]       x_out_q;
	logic [31:0]       y_out_q;

	logic [15:0]       crc_base, crc_next;
	logic              hdr_base, bad;
	logic              emit;
	srfc_pkg::status_t res_status;
	logic [15:0]       got;
	logic [7:0]        b;
	logic [srfc_pkg::IDX_W-1:0] idx;

	assign b   = head.data;
	assign idx = head.idx;

	always_comb begin
		crc_base = (idx == srfc_pkg::IDX_FIRST) ? srfc_pkg::CRC_INIT : crc_q;
		crc_next = (idx < srfc_pkg::IDX_CRC_HI) ? srfc_pkg::crc_update(crc_base, b)
		                                        : crc_base;
		hdr_base = (idx == srfc_pkg::IDX_FIRST) ? 1'b1 : hdr_q;
		bad = ((idx == srfc_pkg::IDX_FIRST || idx == srfc_pkg::IDX_SYNC2)
		       && b != srfc_pkg::SYNC_BYTE)
		   || (idx == srfc_pkg::IDX_ADDR && b != exp_addr)
		   || (idx == srfc_pkg::IDX_CMD && b != srfc_pkg::CMD_BYTE);
		got = {crc_hi_q, b};
		emit = (idx == srfc_pkg::IDX_LAST) || head.short_end;
		priority if (idx != srfc_pkg::IDX_LAST) begin
			res_status = srfc_pkg::ST_SHORT;
		end else if (!hdr_base) begin
			res_status = srfc_pkg::ST_HEADER;
		end else if (got != crc_q) begin
			res_status = srfc_pkg::ST_CRC;
		end else begin
			res_status = srfc_pkg::ST_OK;
		end
	end

	// hold the head while a result would land on a stalled output beat
	assign pop = head_valid && !(emit && out_valid_q && out_stall);

	always_ff @(posedge clk) begin
		if (pop) begin
			crc_q <= crc_next;
			hdr_q <= hdr_base && !bad;
			if (idx >= srfc_pkg::IDX_X_LO && idx <= srfc_pkg::IDX_X_HI) begin
				x_q <= {x_q[23:0], b};
			end
			if (idx >= srfc_pkg::IDX_Y_LO && idx <= srfc_pkg::IDX_Y_HI) begin
				y_q <= {y_q[23:0], b};
			end
			if (idx == srfc_pkg::IDX_CRC_HI) begin
				crc_hi_q <= b;
			end
			if (emit) begin
				status_q <= res_status;
				x_out_q  <= (res_status == srfc_pkg::ST_OK) ? x_q : 32'd0;
				y_out_q  <= (res_status == srfc_pkg::ST_OK) ? y_q : 32'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign x_bits    = x_out_q;
	assign y_bits    = y_out_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != srfc_pkg::ST_OK) |-> (x_out_q == 32'd0 && y_out_q == 32'd0))
		else $error("failed frame carries nonzero values");

endmodule

`default_nettype wire

### src/sensor_reply_frame_checker_core.sv
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker_core
// Checks 19-byte sensor reply frames (sync, address, command, CRC-16) and
// returns one status beat per frame with the two raw float values.
//
// Input channel: in_valid/in_stall carry rx_byte, first_of_frame and
// last_of_frame, one byte per beat. first_of_frame restarts the parser and
// drops any open frame. Bytes after a frame's result are discarded until the
// next first_of_frame.
// Output channel: out_valid/out_stall carry status, x_bits and y_bits. A
// result comes for the 19th byte, or for a last_of_frame byte before it.
// The result beat is registered: an accepted byte passes the two-entry queue
// and then the back end's output register. Throughput is one byte per cycle
// unless a stall holds it; the back end's CRC byte update is combinational.
// A two-entry queue parts the input front end from the back end. While the
// output is stalled with a result waiting, further bytes keep flowing until a
// byte that would give another result reaches the queue head; in_stall then
// rises once the queue is full.
// Reset leaves the parser at byte 0 with expected_address at 0. The address
// register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_reply_frame_checker_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        first_of_frame,
	input  wire logic        last_of_frame,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      x_bits,
	output logic [31:0]      y_bits,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [7:0]       exp_addr_q;
	logic             q_full, q_push, q_pop, head_valid;
	srfc_pkg::entry_t q_entry, head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= 8'h00;
		end else if (psel && penable && pwrite && paddr[2] == srfc_pkg::REG_EXP_ADDR) begin
			exp_addr_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == srfc_pkg::REG_EXP_ADDR) ? {24'd0, exp_addr_q} : 32'd0;

	srfc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (q_entry)
	);

	srfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	srfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.exp_addr   (exp_addr_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.x_bits     (x_bits),
		.y_bits     (y_bits)
	);

endmodule

`default_nettype wire

### sim/frame_reply_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_reply_monitor
// Watches the byte channel, the reply channel and the APB port of the frame
// checker. It keeps its own parser of the reply frames and compares each
// reply beat with the oldest reply that it has worked out.
// ----------------------------------------------------------------------------

module frame_reply_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        first_of_frame,
	input  wire logic        last_of_frame,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic [31:0] x_bits,
	input  wire logic [31:0] y_bits,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output int               errors,
	output int               pending,
	output int               reply_cnt,
	output int               clean_cnt
);

	localparam logic [2:0] EXP_ADDR_OFS = {srfc_pkg::REG_EXP_ADDR, 2'b00};

	typedef struct {
		srfc_pkg::status_t st;
		logic [31:0]       x;
		logic [31:0]       y;
	} reply_t;

	reply_t reply_q[$];

	// parser copy
	logic [7:0]                 addr_reg;
	logic [srfc_pkg::IDX_W-1:0] pos;
	logic [15:0]                crc_acc;
	bit                         hdr_good;
	logic [31:0]                x_acc;
	logic [31:0]                y_acc;
	logic [7:0]                 crc_hi;
	bit                         closed;

	initial begin
		errors    = 0;
		pending   = 0;
		reply_cnt = 0;
		clean_cnt = 0;
	end

	// one bit at a time: feed the data bit into the lsb feedback
	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ srfc_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic open_frame();
		pos      = srfc_pkg::IDX_FIRST;
		crc_acc  = srfc_pkg::CRC_INIT;
		hdr_good = 1'b1;
		x_acc    = 32'h0;
		y_acc    = 32'h0;
		crc_hi   = 8'h00;
		closed   = 1'b0;
	endtask

	task automatic push_reply(input srfc_pkg::status_t st, input logic [31:0] x,
	                          input logic [31:0] y);
		reply_t r;
		r.st = st;
		r.x  = x;
		r.y  = y;
		reply_q.push_back(r);
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic first, input logic last);
		if (first) begin
			open_frame();
		end
		if (closed) begin
			return;
		end
		if (pos < srfc_pkg::IDX_CRC_HI) begin
			crc_acc = crc16_byte(crc_acc, b);
		end
		if ((pos == srfc_pkg::IDX_FIRST || pos == srfc_pkg::IDX_SYNC2)
		    && b != srfc_pkg::SYNC_BYTE) begin
			hdr_good = 1'b0;
		end
		if (pos == srfc_pkg::IDX_ADDR && b != addr_reg) begin
			hdr_good = 1'b0;
		end
		if (pos == srfc_pkg::IDX_CMD && b != srfc_pkg::CMD_BYTE) begin
			hdr_good = 1'b0;
		end
		if (pos >= srfc_pkg::IDX_X_LO && pos <= srfc_pkg::IDX_X_HI) begin
			x_acc = {x_acc[23:0], b};
		end
		if (pos >= srfc_pkg::IDX_Y_LO && pos <= srfc_pkg::IDX_Y_HI) begin
			y_acc = {y_acc[23:0], b};
		end
		if (pos == srfc_pkg::IDX_CRC_HI) begin
			crc_hi = b;
		end
		if (pos == srfc_pkg::IDX_LAST) begin
			closed = 1'b1;
			pos = srfc_pkg::IDX_W'(srfc_pkg::FRAME_LEN);
			// header wins over CRC
			if (!hdr_good) begin
				push_reply(srfc_pkg::ST_HEADER, 32'h0, 32'h0);
			end else if ({crc_hi, b} != crc_acc) begin
				push_reply(srfc_pkg::ST_CRC, 32'h0, 32'h0);
			end else begin
				push_reply(srfc_pkg::ST_OK, x_acc, y_acc);
			end
			return;
		end
		pos = pos + 1'b1;
		if (last) begin
			closed = 1'b1;
			push_reply(srfc_pkg::ST_SHORT, 32'h0, 32'h0);
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_reply();
		reply_t want;
		if (reply_q.size() == 0) begin
			report("reply beat with none outstanding", 32'(status), 32'h0);
		end else begin
			want = reply_q.pop_front();
			if (status !== want.st) begin
				report("status", 32'(status), 32'(want.st));
			end
			if (x_bits !== want.x) begin
				report("x_bits", x_bits, want.x);
			end
			if (y_bits !== want.y) begin
				report("y_bits", y_bits, want.y);
			end
			reply_cnt++;
			if (want.st == srfc_pkg::ST_OK) begin
				clean_cnt++;
			end
		end
	endtask

	// a byte taken at this edge cannot show up as a reply at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_reg = 8'h00;
			open_frame();
			reply_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_reply();
			end
			if (psel && penable && pwrite && pready && paddr == EXP_ADDR_OFS) begin
				addr_reg = pwdata[7:0];
			end
			if (in_valid && !in_stall) begin
				parse_byte(rx_byte, first_of_frame, last_of_frame);
			end
			pending = reply_q.size();
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives reply frames into the sensor reply frame checker: good frames,
// header and CRC faults, short, dropped and noise frames, over several
// address settings, with random gaps and stalls and one long output
// hold-off. The monitor does the checking; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;

	localparam int CYCLE_LIMIT    = 400_000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int PHASE_ITEMS    = 270;
	localparam logic [2:0] EXP_ADDR_OFS = {srfc_pkg::REG_EXP_ADDR, 2'b00};

	typedef enum int {
		FR_GOOD,
		FR_BAD_HDR,
		FR_BAD_CRC,
		FR_SHORT,
		FR_DROPPED
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        first_of_frame;
	logic        last_of_frame;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] x_bits;
	logic [31:0] y_bits;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int errors;
	int pending;
	int reply_cnt;
	int clean_cnt;

	int   cycle_cnt;
	int   backpressure_cnt;
	int   item_cnt;
	int   reg_writes;
	bit   quiet;
	bit   rush;
	bit   holdoff_req;
	logic [7:0] cur_addr;
	logic [7:0] frame_buf [srfc_pkg::FRAME_LEN];

	sensor_reply_frame_checker_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.x_bits         (x_bits),
		.y_bits         (y_bits),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	frame_reply_monitor chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.x_bits         (x_bits),
		.y_bits         (y_bits),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.errors         (errors),
		.pending        (pending),
		.reply_cnt      (reply_cnt),
		.clean_cnt      (clean_cnt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (in_valid && in_stall) begin
			backpressure_cnt++;
		end
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_cnt, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// reply side stall; a hold-off request forces a long solid stall
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				out_stall <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_req = 1'b0;
			end
			out_stall <= !quiet && ($urandom_range(99) < 37);
		end
	end

	// entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		while (!quiet && !rush && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		rx_byte        <= b;
		first_of_frame <= first;
		last_of_frame  <= last;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic apb_write(input logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= EXP_ADDR_OFS;
		pwdata  <= {24'($urandom), v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_addr = v;
		reg_writes++;
	endtask

	// drain replies, let the pipe settle, then change the address
	task automatic new_phase(input logic [7:0] v);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(negedge clk);
		apb_write(v);
	endtask

	task automatic seal_frame();
		logic [15:0] c;
		c = srfc_pkg::CRC_INIT;
		for (int i = 0; i < srfc_pkg::FRAME_LEN - 2; i++) begin
			c = srfc_pkg::crc_update(c, frame_buf[i]);
		end
		frame_buf[srfc_pkg::FRAME_LEN-2] = c[15:8];
		frame_buf[srfc_pkg::FRAME_LEN-1] = c[7:0];
	endtask

	task automatic spoil_header();
		int spot;
		case ($urandom_range(3))
			0:       spot = srfc_pkg::IDX_FIRST;
			1:       spot = srfc_pkg::IDX_SYNC2;
			2:       spot = srfc_pkg::IDX_ADDR;
			default: spot = srfc_pkg::IDX_CMD;
		endcase
		frame_buf[spot] ^= 8'($urandom_range(1, 255));
	endtask

	task automatic send_frame(input frame_kind_t kind, input bit lead,
	                          input logic [31:0] xval, input logic [31:0] yval);
		int len;
		int spot;
		bit tail_last;
		len = srfc_pkg::FRAME_LEN;
		for (int i = 0; i < srfc_pkg::FRAME_LEN; i++) begin
			frame_buf[i] = 8'($urandom);
		end
		frame_buf[srfc_pkg::IDX_FIRST] = srfc_pkg::SYNC_BYTE;
		frame_buf[srfc_pkg::IDX_SYNC2] = srfc_pkg::SYNC_BYTE;
		frame_buf[srfc_pkg::IDX_ADDR]  = cur_addr;
		frame_buf[srfc_pkg::IDX_CMD]   = srfc_pkg::CMD_BYTE;
		for (int i = 0; i < 4; i++) begin
			frame_buf[srfc_pkg::IDX_X_LO + i] = xval[31 - 8*i -: 8];
			frame_buf[srfc_pkg::IDX_Y_LO + i] = yval[31 - 8*i -: 8];
		end
		seal_frame();
		case (kind)
			FR_BAD_HDR: begin
				spoil_header();
				// half of them keep a valid CRC over the bad header
				if ($urandom_range(1)) begin
					seal_frame();
				end
			end
			FR_BAD_CRC: begin
				spot = $urandom_range(srfc_pkg::IDX_CMD + 1, srfc_pkg::FRAME_LEN - 1);
				frame_buf[spot] ^= 8'(1 << $urandom_range(7));
			end
			FR_SHORT: begin
				len = $urandom_range(1, srfc_pkg::FRAME_LEN - 1);
				if ($urandom_range(9) < 3) begin
					spoil_header();
				end
			end
			FR_DROPPED: len = $urandom_range(1, srfc_pkg::FRAME_LEN - 1);
			default: ;
		endcase
		tail_last = (kind != FR_DROPPED)
		            && (len < srfc_pkg::FRAME_LEN || $urandom_range(1));
		for (int i = 0; i < len; i++) begin
			send_byte(frame_buf[i], lead && i == 0, tail_last && i == len - 1);
		end
		item_cnt += len;
		// bytes after the reply are ignored by the block
		if (kind != FR_DROPPED) begin
			repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(19))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_frame();
		int r;
		r = $urandom_range(99);
		if (r < 50) begin
			send_frame(FR_GOOD, 1'b1, pick_value(), pick_value());
		end else if (r < 62) begin
			send_frame(FR_BAD_HDR, 1'b1, pick_value(), pick_value());
		end else if (r < 74) begin
			send_frame(FR_BAD_CRC, 1'b1, pick_value(), pick_value());
		end else if (r < 88) begin
			send_frame(FR_SHORT, 1'b1, pick_value(), pick_value());
		end else if (r < 94) begin
			send_frame(FR_DROPPED, 1'b1, pick_value(), pick_value());
		end else begin
			// noise with random frame marks
			repeat ($urandom_range(1, 4)) begin
				send_byte(8'($urandom), 1'($urandom_range(3) == 0), 1'($urandom_range(3) == 0));
				item_cnt++;
			end
		end
	endtask

	initial begin
		logic [7:0] phase_addr [4];
		bit held;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		rx_byte        = 8'h00;
		first_of_frame = 1'b0;
		last_of_frame  = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = 3'b000;
		pwdata         = 32'h0;
		cycle_cnt        = 0;
		backpressure_cnt = 0;
		item_cnt         = 0;
		reg_writes       = 0;
		quiet            = 1'b0;
		rush             = 1'b0;
		holdoff_req      = 1'b0;
		held             = 1'b0;
		cur_addr         = 8'h00;
		phase_addr[0] = 8'hFF;
		phase_addr[1] = 8'($urandom_range(1, 254));
		phase_addr[2] = 8'h00;
		phase_addr[3] = 8'($urandom);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed, at the reset address: frame with no leading mark
		send_frame(FR_GOOD, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
		// one-byte frame
		send_byte(8'hFF, 1'b1, 1'b1);
		// short frame with a bad sync byte, then ignored bytes
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(srfc_pkg::SYNC_BYTE, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		item_cnt += 4;
		send_byte(8'h5A, 1'b0, 1'b1);
		send_byte(srfc_pkg::SYNC_BYTE, 1'b0, 1'b0);

		for (int p = 0; p < 4; p++) begin
			new_phase(phase_addr[p]);
			quiet = (p == 2);
			while (item_cnt < 23 + (p + 1) * PHASE_ITEMS) begin
				if (p == 1 && !held && item_cnt > 23 + PHASE_ITEMS + PHASE_ITEMS / 2) begin
					// hold the reply side off while one-byte frames keep coming
					held = 1'b1;
					rush = 1'b1;
					holdoff_req = 1'b1;
					repeat (30) begin
						send_byte(8'($urandom), 1'b1, 1'b1);
						item_cnt++;
					end
					in_valid <= 1'b0;
					wait (!holdoff_req);
					rush = 1'b0;
					wait (pending == 0);
					@(negedge clk);
				end
				random_frame();
			end
			quiet = 1'b0;
		end

		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (10) @(posedge clk);

		$display("covered %0d frame bytes and %0d replies, %0d of them clean frames",
		         item_cnt, reply_cnt, clean_cnt);
		$display("%0d address writes; byte input held back for %0d cycles",
		         reg_writes, backpressure_cnt);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
